// ===== design/sliding_door_controller_unit_defines.svh =====
// assertion macros used by the sliding door controller checker
`ifndef SLIDING_DOOR_CONTROLLER_UNIT_DEFINES_SVH
`define SLIDING_DOOR_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdc_pkg.sv =====
// types and constants of the sliding door controller
package sdc_pkg;

  typedef enum logic [2:0] {
    CMD_SLOW_TICK = 3'd0,
    CMD_FAST_TICK = 3'd1,
    CMD_BUTTON_X  = 3'd2,
    CMD_BUTTON_Y  = 3'd3,
    CMD_BUTTON_Z  = 3'd4,
    CMD_BUTTON_T  = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLOSED  = 5'b00001,
    ST_OPENING = 5'b00010,
    ST_WAITING = 5'b00100,
    ST_OPENED  = 5'b01000,
    ST_CLOSING = 5'b10000
  } door_state_t;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_WAIT = 2'd1,
    CH_MODE = 2'd2
  } choice_t;

  typedef enum logic [2:0] {
    DK_DOOR = 3'd0,
    DK_CONF = 3'd1,
    DK_WAIT = 3'd2,
    DK_AUTO = 3'd3,
    DK_HAND = 3'd4
  } display_t;

  // door status codes as seen on the result channel
  localparam logic [2:0] STC_CLOSED  = 3'd0;
  localparam logic [2:0] STC_OPENING = 3'd1;
  localparam logic [2:0] STC_WAITING = 3'd2;
  localparam logic [2:0] STC_OPENED  = 3'd3;
  localparam logic [2:0] STC_CLOSING = 3'd4;

  localparam int unsigned ADC_W     = 12;
  localparam int unsigned WAIT_W    = 5;
  localparam int unsigned WAIT_BASE = 10;
  localparam int unsigned WAIT_SPAN = 20;
  localparam int unsigned ADC_FULL  = 4095;

  function automatic logic [2:0] status_code(door_state_t st);
    logic [2:0] code;
    case (st)
      ST_CLOSED:  code = STC_CLOSED;
      ST_OPENING: code = STC_OPENING;
      ST_WAITING: code = STC_WAITING;
      ST_OPENED:  code = STC_OPENED;
      ST_CLOSING: code = STC_CLOSING;
      default:    code = STC_CLOSED;
    endcase
    return code;
  endfunction

endpackage

// ===== design/sliding_door_controller_unit.sv =====
// Sliding door controller. Takes one item per clock while in_stall is low: a
// slow tick, a fast tick or a button press, and returns one item carrying the
// controller state after that command. An item waits in the input register and
// is then applied to the state; the state registers are the result register, so
// a new item can follow every cycle unless the pending result is stalled.
// in_stall rises only while the input register holds an item and the pending
// result is stalled.
module sliding_door_controller_unit #(
  parameter int unsigned FULL_OPEN      = 4,
  parameter int unsigned TICKS_PER_STEP = 2,
  parameter int unsigned FLASH_TICKS    = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_command,
  input  logic [sdc_pkg::ADC_W-1:0]          in_adc_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [$clog2(FULL_OPEN+1)-1:0]     out_door_position,
  output logic [2:0]                         out_door_status,
  output logic                               out_manual_mode,
  output logic                               out_in_settings,
  output logic [2:0]                         out_display_kind,
  output logic [sdc_pkg::WAIT_W-1:0]         out_wait_limit_now,
  output logic                               out_settings_lamp,
  output logic                               out_manual_lamp,
  output logic                               out_door_lamp
);
  import sdc_pkg::*;

  localparam int unsigned PW = $clog2(FULL_OPEN + 1);
  localparam int unsigned SW = $clog2(TICKS_PER_STEP + 1);
  localparam int unsigned FW = $clog2(FLASH_TICKS + 1);
  localparam int unsigned PRODW = ADC_W + 5;

  // input register
  logic              s1_valid_r;
  logic [2:0]        s1_cmd_r;
  logic [ADC_W-1:0]  s1_adc_r;
  logic              advance;
  logic              accept;

  // controller state, also the result register
  logic              out_valid_r;
  logic              settings_r, settings_nxt;
  logic              manual_r, manual_nxt;
  door_state_t       status_r, status_nxt;
  choice_t           choice_r, choice_nxt;
  logic [WAIT_W-1:0] wait_limit_r, wait_limit_nxt;
  logic [SW-1:0]     open_cnt_r, open_cnt_nxt;
  logic [SW-1:0]     close_cnt_r, close_cnt_nxt;
  logic [WAIT_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [FW-1:0]     flash_cnt_r, flash_cnt_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  display_t          display_r, display_nxt;
  logic              lamp_set_r, lamp_set_nxt;
  logic              lamp_man_r, lamp_man_nxt;
  logic              lamp_door_r, lamp_door_nxt;

  // helpers
  logic [SW-1:0]     open_inc, close_inc;
  logic              open_done, close_done;
  logic [PW-1:0]     pos_dec;
  logic [WAIT_W-1:0] wait_inc;
  logic [FW-1:0]     flash_inc;
  logic [PRODW-1:0]  adc_prod;
  logic [ADC_W:0]    fold_sum;
  logic [WAIT_W-1:0] scaled;
  logic [WAIT_W-1:0] adc_limit;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign open_inc   = open_cnt_r + SW'(1);
  assign close_inc  = close_cnt_r + SW'(1);
  assign open_done  = open_inc >= SW'(TICKS_PER_STEP);
  assign close_done = close_inc >= SW'(TICKS_PER_STEP);
  assign pos_dec    = (pos_r != '0) ? pos_r - PW'(1) : pos_r;
  assign wait_inc   = wait_cnt_r + WAIT_W'(1);
  assign flash_inc  = flash_cnt_r + FW'(1);

  // adc*20/4095: with x = a*4096 + b, x/4095 = a + ((a + b) >= 4095)
  assign adc_prod  = PRODW'(s1_adc_r) * PRODW'(WAIT_SPAN);
  assign fold_sum  = (ADC_W+1)'(adc_prod[ADC_W-1:0]) + (ADC_W+1)'(adc_prod[PRODW-1:ADC_W]);
  assign scaled    = WAIT_W'(adc_prod[PRODW-1:ADC_W])
                   + WAIT_W'(fold_sum >= (ADC_W+1)'(ADC_FULL));
  assign adc_limit = WAIT_W'(WAIT_BASE) + scaled;

  always_comb begin
    settings_nxt   = settings_r;
    manual_nxt     = manual_r;
    status_nxt     = status_r;
    choice_nxt     = choice_r;
    wait_limit_nxt = wait_limit_r;
    open_cnt_nxt   = open_cnt_r;
    close_cnt_nxt  = close_cnt_r;
    wait_cnt_nxt   = wait_cnt_r;
    flash_cnt_nxt  = flash_cnt_r;
    pos_nxt        = pos_r;
    display_nxt    = display_r;
    lamp_set_nxt   = lamp_set_r;
    lamp_man_nxt   = lamp_man_r;
    lamp_door_nxt  = lamp_door_r;

    case (cmd_t'(s1_cmd_r))
      CMD_SLOW_TICK: begin
        if (!settings_r) begin
          lamp_set_nxt = 1'b0;
          display_nxt  = DK_DOOR;
          lamp_man_nxt = manual_r;
          if (status_r == ST_OPENING) begin
            open_cnt_nxt = open_done ? '0 : open_inc;
            if (open_done) begin
              if (pos_r < PW'(FULL_OPEN)) begin
                pos_nxt = pos_r + PW'(1);
              end else begin
                status_nxt = manual_r ? ST_OPENED : ST_WAITING;
              end
            end
          end else if (status_r == ST_CLOSING) begin
            close_cnt_nxt = close_done ? '0 : close_inc;
            if (close_done) begin
              pos_nxt = pos_dec;
              if (pos_dec == '0) begin
                status_nxt = ST_CLOSED;
                if (!manual_r) begin
                  lamp_door_nxt = 1'b0;
                end
              end
            end
          end else if (status_r == ST_WAITING && !manual_r) begin
            lamp_door_nxt = 1'b1;
            if (wait_inc >= wait_limit_r) begin
              wait_cnt_nxt = '0;
              status_nxt   = ST_CLOSING;
            end else begin
              wait_cnt_nxt = wait_inc;
            end
          end
          // manual mode shows the settled door on its lamp
          if (manual_r) begin
            if (status_nxt == ST_OPENED) begin
              lamp_door_nxt = 1'b1;
            end
            if (status_nxt == ST_CLOSED) begin
              lamp_door_nxt = 1'b0;
            end
          end
        end else begin
          lamp_set_nxt = 1'b1;
          case (choice_r)
            CH_NONE: display_nxt = DK_CONF;
            CH_WAIT: begin
              wait_limit_nxt = adc_limit;
              display_nxt    = DK_WAIT;
            end
            CH_MODE: display_nxt = manual_r ? DK_HAND : DK_AUTO;
            default: display_nxt = display_r;
          endcase
        end
      end
      CMD_FAST_TICK: begin
        if (status_r == ST_OPENING || status_r == ST_CLOSING) begin
          if (flash_inc >= FW'(FLASH_TICKS)) begin
            flash_cnt_nxt = '0;
            lamp_door_nxt = !lamp_door_r;
          end else begin
            flash_cnt_nxt = flash_inc;
          end
        end
      end
      CMD_BUTTON_X, CMD_BUTTON_Y: begin
        if (!settings_r) begin
          // photocell in auto mode
          if (!manual_r) begin
            if (status_r == ST_CLOSED || status_r == ST_CLOSING) begin
              status_nxt = ST_OPENING;
            end else if (status_r == ST_WAITING) begin
              wait_cnt_nxt = '0;
            end
          end
        end else if (cmd_t'(s1_cmd_r) == CMD_BUTTON_X) begin
          choice_nxt = CH_WAIT;
        end else begin
          choice_nxt = CH_MODE;
          manual_nxt = !manual_r;
        end
      end
      CMD_BUTTON_Z: begin
        if (!settings_r && manual_r) begin
          if (status_r == ST_CLOSED) begin
            status_nxt = ST_OPENING;
          end else if (status_r == ST_OPENED) begin
            status_nxt = ST_CLOSING;
          end
        end
      end
      CMD_BUTTON_T: settings_nxt = !settings_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= in_command;
      s1_adc_r <= in_adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      settings_r   <= 1'b0;
      manual_r     <= 1'b0;
      status_r     <= ST_CLOSED;
      choice_r     <= CH_NONE;
      wait_limit_r <= WAIT_W'(WAIT_BASE);
      open_cnt_r   <= '0;
      close_cnt_r  <= '0;
      wait_cnt_r   <= '0;
      flash_cnt_r  <= '0;
      pos_r        <= '0;
      display_r    <= DK_DOOR;
      lamp_set_r   <= 1'b0;
      lamp_man_r   <= 1'b0;
      lamp_door_r  <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && out_stall);
      if (advance) begin
        settings_r   <= settings_nxt;
        manual_r     <= manual_nxt;
        status_r     <= status_nxt;
        choice_r     <= choice_nxt;
        wait_limit_r <= wait_limit_nxt;
        open_cnt_r   <= open_cnt_nxt;
        close_cnt_r  <= close_cnt_nxt;
        wait_cnt_r   <= wait_cnt_nxt;
        flash_cnt_r  <= flash_cnt_nxt;
        pos_r        <= pos_nxt;
        display_r    <= display_nxt;
        lamp_set_r   <= lamp_set_nxt;
        lamp_man_r   <= lamp_man_nxt;
        lamp_door_r  <= lamp_door_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_door_position  = pos_r;
  assign out_door_status    = status_code(status_r);
  assign out_manual_mode    = manual_r;
  assign out_in_settings    = settings_r;
  assign out_display_kind   = display_r;
  assign out_wait_limit_now = wait_limit_r;
  assign out_settings_lamp  = lamp_set_r;
  assign out_manual_lamp    = lamp_man_r;
  assign out_door_lamp      = lamp_door_r;

endmodule

// ===== design/sdc_checker.sv =====
// port-level checker for the sliding door controller, bound to the top level
`include "sliding_door_controller_unit_defines.svh"

module sdc_checker #(
  parameter int unsigned FULL_OPEN = 4
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [$clog2(FULL_OPEN+1)-1:0] out_door_position,
  input logic [2:0]                     out_door_status,
  input logic [2:0]                     out_display_kind,
  input logic [sdc_pkg::WAIT_W-1:0]     out_wait_limit_now,
  input logic                           out_door_lamp
);
  import sdc_pkg::*;

  localparam int unsigned PW = $clog2(FULL_OPEN + 1);

  `SDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_door_position) && $stable(out_door_status) && $stable(out_display_kind) && $stable(out_wait_limit_now) && $stable(out_door_lamp), "stalled result item changed")
  `SDC_ASSERT_IMPL(a_wait_range, clk, rst_n, out_valid, out_wait_limit_now >= WAIT_W'(WAIT_BASE) && out_wait_limit_now <= WAIT_W'(WAIT_BASE + WAIT_SPAN), "wait limit out of range")
  `SDC_ASSERT_IMPL(a_closed_pos, clk, rst_n, out_valid && out_door_status == STC_CLOSED, out_door_position == '0, "closed door not at position zero")
  `SDC_ASSERT_IMPL(a_open_pos, clk, rst_n, out_valid && (out_door_status == STC_WAITING || out_door_status == STC_OPENED), out_door_position == PW'(FULL_OPEN), "open door not fully open")

endmodule

bind sliding_door_controller_unit sdc_checker #(.FULL_OPEN(FULL_OPEN)) u_sdc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_door_position  (out_door_position),
  .out_door_status    (out_door_status),
  .out_display_kind   (out_display_kind),
  .out_wait_limit_now (out_wait_limit_now),
  .out_door_lamp      (out_door_lamp)
);
